/* rtl/core/sha256_hash_core_macros.svh */
// Assertion helpers shared by the hash core modules.
// Each macro expects aclk and aresetn to be visible in the module that uses it.
`ifndef SHA256_HASH_CORE_MACROS_SVH
`define SHA256_HASH_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SHA256_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SHA256_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/sha256_pkg.sv */
package sha256_pkg;

    // Input beat: one optional message byte plus end marker
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } in_item_t;

    // Output beat: one digest word
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        last_word;
    } out_item_t;

    // Source of a byte shifted into the block register
    localparam logic [1:0] SRC_DATA = 2'd0;
    localparam logic [1:0] SRC_PAD  = 2'd1;
    localparam logic [1:0] SRC_ZERO = 2'd2;
    localparam logic [1:0] SRC_LEN  = 2'd3;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LAST_POS   = 6'd63;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [2:0] LAST_WORD  = 3'd7;

    // Controller to datapath commands
    typedef struct packed {
        logic       push;
        logic [1:0] push_sel;
        logic       latch_len;
        logic       load_work;
        logic       do_round;
        logic       add_chain;
        logic       restart;
        logic [5:0] rnd;
        logic [2:0] out_idx;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [5:0] pos;
    } sts_t;

    typedef logic [0:7][31:0] chain_t;

    localparam chain_t H_INIT = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sig0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sig1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                           input logic [31:0] g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

    // Round constants
    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

endpackage

/* rtl/core/sha256_dp.sv */
`include "sha256_hash_core_macros.svh"

module sha256_dp (
    input  logic               aclk,
    input  logic               aresetn,
    input  sha256_pkg::cmd_t   cmd,
    input  logic [7:0]         data_byte,
    output sha256_pkg::sts_t   sts,
    output logic [31:0]        digest_word
);
    import sha256_pkg::*;

    logic [60:0]  cnt_reg,   cnt_next;
    chain_t       chain_reg, chain_next;
    logic [63:0]  len_reg,   len_next;
    logic [511:0] sched_reg, sched_next;
    chain_t       work_reg,  work_next;

    logic [7:0]   push_byte;
    logic [31:0]  w_cur;
    logic [31:0]  w_new;
    logic [31:0]  t1;
    logic [31:0]  t2;

    // Pick the byte to shift in
    always_comb begin
        unique case (cmd.push_sel)
            SRC_DATA: push_byte = data_byte;
            SRC_PAD:  push_byte = PAD_BYTE;
            SRC_ZERO: push_byte = 8'h00;
            SRC_LEN:  push_byte = len_reg[63:56];
            default:  push_byte = 8'h00;
        endcase
    end

    // Schedule word for this round and the word sixteen rounds ahead
    assign w_cur = sched_reg[511:480];
    assign w_new = w_cur + small_sig0(sched_reg[479:448]) + sched_reg[223:192]
                 + small_sig1(sched_reg[63:32]);

    // Round function
    assign t1 = work_reg[7] + big_sig1(work_reg[4])
              + choose(work_reg[4], work_reg[5], work_reg[6]) + round_k(cmd.rnd) + w_cur;
    assign t2 = big_sig0(work_reg[0]) + majority(work_reg[0], work_reg[1], work_reg[2]);

    // Next state of counter and chaining words
    always_comb begin
        cnt_next   = cnt_reg;
        chain_next = chain_reg;
        if (cmd.restart) begin
            cnt_next   = '0;
            chain_next = H_INIT;
        end else begin
            if (cmd.push) begin
                cnt_next = cnt_reg + 61'd1;
            end
            if (cmd.add_chain) begin
                for (int i = 0; i < 8; i++) begin
                    chain_next[i] = chain_reg[i] + work_reg[i];
                end
            end
        end
    end

    // Next state of block, length and working registers
    always_comb begin
        len_next   = len_reg;
        sched_next = sched_reg;
        work_next  = work_reg;
        if (cmd.latch_len) begin
            len_next = {cnt_reg, 3'b000};
        end else if (cmd.push && (cmd.push_sel == SRC_LEN)) begin
            len_next = {len_reg[55:0], 8'h00};
        end
        if (cmd.push) begin
            sched_next = {sched_reg[503:0], push_byte};
        end else if (cmd.do_round) begin
            sched_next = {sched_reg[479:0], w_new};
        end
        if (cmd.load_work) begin
            work_next = chain_reg;
        end else if (cmd.do_round) begin
            work_next = '{t1 + t2, work_reg[0], work_reg[1], work_reg[2],
                          work_reg[3] + t1, work_reg[4], work_reg[5], work_reg[6]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            chain_reg <= H_INIT;
        end else begin
            cnt_reg   <= cnt_next;
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg   <= len_next;
        sched_reg <= sched_next;
        work_reg  <= work_next;
    end

    assign sts.pos     = cnt_reg[5:0];
    assign digest_word = chain_reg[cmd.out_idx];

    `SHA256_ASSERT_NEXT(a_block_wrap, cmd.push && (cnt_reg[5:0] == LAST_POS), cnt_reg[5:0] == 6'd0, "byte position did not wrap after a full block")
    `SHA256_ASSERT_NEXT(a_work_load, cmd.load_work, work_reg == $past(chain_reg), "working registers not loaded from chaining words")
    `SHA256_ASSERT_NEXT(a_restart, cmd.restart, (cnt_reg == 61'd0) && (chain_reg == H_INIT), "restart did not return to the initial value")

endmodule

/* rtl/core/sha256_ctrl.sv */
`include "sha256_hash_core_macros.svh"

module sha256_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  byte_present,
    input  logic                  end_of_message,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [2:0]            word_number,
    output logic                  last_word,
    input  sha256_pkg::sts_t      sts,
    output sha256_pkg::cmd_t      cmd
);
    import sha256_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD80 = 3'd1;
    localparam logic [2:0] ST_ZERO  = 3'd2;
    localparam logic [2:0] ST_LEN   = 3'd3;
    localparam logic [2:0] ST_LOAD  = 3'd4;
    localparam logic [2:0] ST_COMP  = 3'd5;
    localparam logic [2:0] ST_ADD   = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    // What follows a compression
    localparam logic [1:0] PH_DATA  = 2'd0;
    localparam logic [1:0] PH_PAD   = 2'd1;
    localparam logic [1:0] PH_FINAL = 2'd2;

    logic [2:0] state_reg, state_next;
    logic [1:0] phase_reg, phase_next;
    logic       pend_reg,  pend_next;
    logic [5:0] rnd_reg,   rnd_next;
    logic [2:0] idx_reg,   idx_next;

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        pend_next  = pend_reg;
        rnd_next   = rnd_reg;
        idx_next   = idx_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        cmd        = '0;
        cmd.rnd     = rnd_reg;
        cmd.out_idx = idx_reg;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (byte_present) begin
                        cmd.push     = 1'b1;
                        cmd.push_sel = SRC_DATA;
                        if (sts.pos == LAST_POS) begin
                            state_next = ST_LOAD;
                            phase_next = PH_DATA;
                            pend_next  = end_of_message;
                        end else if (end_of_message) begin
                            state_next = ST_PAD80;
                        end
                    end else if (end_of_message) begin
                        state_next = ST_PAD80;
                    end
                end
            end
            ST_PAD80: begin
                // capture bit length, then append the marker byte
                cmd.latch_len = 1'b1;
                cmd.push      = 1'b1;
                cmd.push_sel  = SRC_PAD;
                if (sts.pos == LAST_POS) begin
                    state_next = ST_LOAD;
                    phase_next = PH_PAD;
                end else begin
                    state_next = ST_ZERO;
                end
            end
            ST_ZERO: begin
                if (sts.pos == LEN_POS) begin
                    state_next = ST_LEN;
                end else begin
                    cmd.push     = 1'b1;
                    cmd.push_sel = SRC_ZERO;
                    if (sts.pos == LAST_POS) begin
                        state_next = ST_LOAD;
                        phase_next = PH_PAD;
                    end
                end
            end
            ST_LEN: begin
                cmd.push     = 1'b1;
                cmd.push_sel = SRC_LEN;
                if (sts.pos == LAST_POS) begin
                    state_next = ST_LOAD;
                    phase_next = PH_FINAL;
                end
            end
            ST_LOAD: begin
                cmd.load_work = 1'b1;
                rnd_next      = '0;
                state_next    = ST_COMP;
            end
            ST_COMP: begin
                cmd.do_round = 1'b1;
                rnd_next     = rnd_reg + 6'd1;
                if (rnd_reg == LAST_ROUND) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                cmd.add_chain = 1'b1;
                case (phase_reg)
                    PH_DATA:  state_next = pend_reg ? ST_PAD80 : ST_IDLE;
                    PH_PAD:   state_next = ST_ZERO;
                    default: begin
                        state_next = ST_OUT;
                        idx_next   = '0;
                    end
                endcase
                pend_next = 1'b0;
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (idx_reg == LAST_WORD) begin
                        cmd.restart = 1'b1;
                        state_next  = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_DATA;
            pend_reg  <= 1'b0;
            rnd_reg   <= '0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            pend_reg  <= pend_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
        end
    end

    assign word_number = idx_reg;
    assign last_word   = (idx_reg == LAST_WORD);

    `SHA256_ASSERT_IMP(a_no_overlap, 1'b1, !(s_ready && m_valid), "input and output open together")
    `SHA256_ASSERT_NEXT(a_round_step, (state_reg == ST_COMP) && (rnd_reg != LAST_ROUND), (state_reg == ST_COMP) && (rnd_reg == $past(rnd_reg) + 6'd1), "round counter skipped")
    `SHA256_ASSERT_NEXT(a_final_out, (state_reg == ST_ADD) && (phase_reg == PH_FINAL), (state_reg == ST_OUT) && (idx_reg == 3'd0), "final compression did not start the digest")

endmodule

/* rtl/core/sha256_hash_core.sv */
// SHA-256 stream hasher.
// Input channel (s_valid/s_ready/s_data): one beat per item; a beat may carry
// one message byte (byte_present) and/or close the message (end_of_message).
// A beat with neither flag set is dropped. An end beat with no byte before it
// hashes the empty message.
// Output channel (m_valid/m_ready/m_data): eight digest words per message,
// word 0 first, last_word set on word 7.
// Flow: a byte beat is taken while idle; every 64th byte also runs one block
// compression (load, 64 rounds, chain add) during which s_ready is low. An
// end beat pads one byte per cycle up to the length field (except while a
// compression runs, and with one idle step just before the length bytes),
// runs one or two compressions, then presents the digest from the chaining
// registers.
// The rate is set by the single round unit, which does one round per cycle.
// If the receiver stalls, the current word holds and no input is taken until
// the eighth word is accepted; then the core returns to the initial value.
// Reset (aresetn low, synchronous) loads the initial value, clears the byte
// count and returns to idle, ready for a new message.
module sha256_hash_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  sha256_pkg::in_item_t   s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output sha256_pkg::out_item_t  m_data
);
    import sha256_pkg::*;

    cmd_t        cmd;
    sts_t        sts;
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        last_word;

    sha256_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .byte_present   (s_data.byte_present),
        .end_of_message (s_data.end_of_message),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .word_number    (word_number),
        .last_word      (last_word),
        .sts            (sts),
        .cmd            (cmd)
    );

    sha256_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .data_byte   (s_data.data_byte),
        .sts         (sts),
        .digest_word (digest_word)
    );

    // Pack the result beat
    assign m_data.digest_word = digest_word;
    assign m_data.word_number = word_number;
    assign m_data.last_word   = last_word;

endmodule

/* dv/sha256_hash_checker.sv */
`timescale 1ns / 1ps

// Watches both channels of the hash core, keeps its own SHA-256 state and
// compares every digest word that leaves the core with the predicted one.
module sha256_hash_checker (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  sha256_pkg::in_item_t  s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  sha256_pkg::out_item_t m_data,
    output int                    mismatches,
    output int                    pending
);

    import sha256_pkg::*;

    localparam int         REPORT_MAX = 10;
    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam int         LEN_START  = 56;

    localparam logic [0:7][31:0] SEED_H = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [0:63][31:0] RC = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Predicted hash state
    logic [31:0] chain_h [8];
    logic [7:0]  blk_bytes [64];
    logic [60:0] msg_bytes;

    out_item_t digest_q [$];
    int        err_count;

    assign mismatches = err_count;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Fold the 64-byte block into the chaining words
    task automatic run_compression();
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] x, y, t1, t2;
        int j;
        for (j = 0; j < 16; j++) begin
            w[j] = {blk_bytes[4*j], blk_bytes[4*j+1], blk_bytes[4*j+2], blk_bytes[4*j+3]};
        end
        for (j = 0; j < 8; j++) begin
            v[j] = chain_h[j];
        end
        for (j = 0; j < 64; j++) begin
            // extend the schedule in place
            if (j >= 16) begin
                x = w[(j + 1) & 15];
                y = w[(j + 14) & 15];
                w[j & 15] = w[j & 15] + (ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3))
                          + w[(j + 9) & 15] + (ror32(y, 17) ^ ror32(y, 19) ^ (y >> 10));
            end
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RC[j] + w[j & 15];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (j = 0; j < 8; j++) begin
            chain_h[j] = chain_h[j] + v[j];
        end
    endtask

    task automatic restart_message();
        int i;
        for (i = 0; i < 8; i++) begin
            chain_h[i] = SEED_H[i];
        end
        msg_bytes = '0;
    endtask

    // Take one input beat; an end beat pads, finishes and queues the digest
    task automatic absorb_beat(input in_item_t beat);
        int          pos;
        int          i;
        logic [63:0] bit_len;
        out_item_t   word;
        if (beat.byte_present) begin
            pos = int'(msg_bytes[5:0]);
            blk_bytes[pos] = beat.data_byte;
            msg_bytes = msg_bytes + 61'd1;
            if (pos == 63) begin
                run_compression();
            end
        end
        if (beat.end_of_message) begin
            pos = int'(msg_bytes[5:0]);
            bit_len = {msg_bytes, 3'b000};
            blk_bytes[pos] = PAD_MARK;
            // no room for the length field: close this block with zeros first
            if (pos >= LEN_START) begin
                for (i = pos + 1; i < 64; i++) begin
                    blk_bytes[i] = 8'h00;
                end
                run_compression();
                for (i = 0; i < LEN_START; i++) begin
                    blk_bytes[i] = 8'h00;
                end
            end else begin
                for (i = pos + 1; i < LEN_START; i++) begin
                    blk_bytes[i] = 8'h00;
                end
            end
            for (i = 0; i < 8; i++) begin
                blk_bytes[LEN_START + i] = bit_len[63 - 8*i -: 8];
            end
            run_compression();
            for (i = 0; i < 8; i++) begin
                word.digest_word = chain_h[i];
                word.word_number = 3'(i);
                word.last_word   = (i == 7);
                digest_q = {digest_q, word};
            end
            restart_message();
        end
    endtask

    // Check result beats first, then fold in the input beat of this edge
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            restart_message();
            digest_q.delete();
            err_count = 0;
            pending   = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (digest_q.size() == 0) begin
                    if (err_count < REPORT_MAX) begin
                        $display("%0t: unexpected digest word %h (word %0d, last %0d)",
                                 $time, m_data.digest_word, m_data.word_number,
                                 m_data.last_word);
                    end
                    err_count++;
                end else begin
                    want = digest_q.pop_front();
                    if (m_data.digest_word !== want.digest_word ||
                        m_data.word_number !== want.word_number ||
                        m_data.last_word !== want.last_word) begin
                        if (err_count < REPORT_MAX) begin
                            $display("%0t: digest beat wrong: expected %h/%0d/%0d, got %h/%0d/%0d",
                                     $time, want.digest_word, want.word_number,
                                     want.last_word, m_data.digest_word,
                                     m_data.word_number, m_data.last_word);
                        end
                        err_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                absorb_beat(s_data);
            end
            pending = digest_q.size();
        end
    end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;

    import sha256_pkg::*;

    localparam int ITEM_TARGET = 210;
    localparam int IDLE_LIMIT  = 5000;
    localparam int RX_HOLD     = 400;
    localparam int DRAIN_WAIT  = 200;

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    int  mismatch_total;
    int  digest_pending;
    int  items_sent;
    bit  tx_burst;

    sha256_hash_core uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    sha256_hash_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .mismatches (mismatch_total),
        .pending    (digest_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Mostly short idle stretches, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic in_item_t mk_beat(input logic [7:0] b, input logic has_byte,
                                         input logic ends);
        in_item_t it;
        it.data_byte      = b;
        it.byte_present   = has_byte;
        it.end_of_message = ends;
        return it;
    endfunction

    // Offer one beat and hold it until the core takes it
    task automatic send_beat(input in_item_t it);
        int gap;
        gap = tx_burst ? 0 : idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            s_data  <= mk_beat(8'($urandom), 1'($urandom), 1'($urandom));
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    // One message of random bytes, sprinkled with dropped beats
    task automatic send_message(input int len);
        int  k;
        bit  merge_end;
        merge_end = 1'($urandom_range(0, 1));
        tx_burst  = ($urandom_range(0, 3) == 0);
        for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                send_beat(mk_beat(8'($urandom), 1'b0, 1'b0));
                items_sent++;
            end
            send_beat(mk_beat(8'($urandom), 1'b1, merge_end && (k == len - 1)));
            items_sent++;
        end
        if (!merge_end || len == 0) begin
            send_beat(mk_beat(8'($urandom), 1'b0, 1'b1));
            items_sent++;
        end
    endtask

    // Result side: long hold-off first so the core backs up, then random stalls
    initial begin : rx_side
        int gap;
        while (!aresetn) @(posedge aclk);
        repeat (RX_HOLD) @(posedge aclk);
        forever begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(20, 60)) @(posedge aclk);
            end else begin
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
            gap = idle_len();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    // End the run if neither channel moves for too long
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin : stimulus
        int r;
        int len;
        items_sent = 0;
        tx_burst   = 1'b0;
        aresetn <= 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty message, a dropped beat, then "abc" with byte and end together
        send_beat(mk_beat(8'h00, 1'b0, 1'b1));
        send_beat(mk_beat(8'hff, 1'b0, 1'b0));
        send_beat(mk_beat(8'h61, 1'b1, 1'b0));
        send_beat(mk_beat(8'h62, 1'b1, 1'b0));
        send_beat(mk_beat(8'h63, 1'b1, 1'b1));
        // extreme bytes, closed by an end beat without a byte
        send_beat(mk_beat(8'h00, 1'b1, 1'b0));
        send_beat(mk_beat(8'hff, 1'b1, 1'b0));
        send_beat(mk_beat(8'h5a, 1'b0, 1'b1));
        // one-byte message
        send_beat(mk_beat(8'hff, 1'b1, 1'b1));
        items_sent = 9;

        // lengths cluster around the block edge to hit one- and two-block padding
        while (items_sent < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                len = $urandom_range(0, 12);
            end else if (r < 75) begin
                len = $urandom_range(52, 70);
            end else begin
                len = $urandom_range(13, 51);
            end
            // trim the last message so the run stays near the item target
            if (len > ITEM_TARGET - items_sent) begin
                len = ITEM_TARGET - items_sent;
            end
            send_message(len);
        end
        s_valid <= 1'b0;

        // drain the outstanding digest words
        do @(posedge aclk); while (digest_pending != 0);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (mismatch_total == 0 && digest_pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/sha256_pkg.sv
rtl/core/sha256_dp.sv
rtl/core/sha256_ctrl.sv
rtl/core/sha256_hash_core.sv
dv/sha256_hash_checker.sv
dv/tb.sv
